/* rtl/core/rcws_pkg.sv */
// Shared constants, codes and types of the raycaster wall column shader.
package rcws_pkg;

   localparam int TEX_SIZE    = 64;
   localparam int MAX_HEIGHT  = 1024;
   localparam int MAX_WIDTH   = 2048;

   localparam int TY_BITS     = $clog2(TEX_SIZE);
   localparam int HALF_TEX    = TEX_SIZE / 2;
   localparam int FACE_TEXELS = TEX_SIZE * TEX_SIZE;
   localparam int STORE_DEPTH = 4 * FACE_TEXELS;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int NUM_BITS    = 16 + TY_BITS;
   localparam int DIV_STAGES  = TY_BITS + 1;
   localparam int SPAN_BITS   = 18;

   localparam logic CMD_LOAD  = 1'b0;

   typedef enum logic [1:0] {
      FACE_NORTH,
      FACE_SOUTH,
      FACE_EAST,
      FACE_WEST
   } face_type;

   typedef enum logic [2:0] {
      KIND_LOAD,
      KIND_SKY,
      KIND_WALL,
      KIND_GROUND,
      KIND_DROP
   } kind_type;

   typedef enum logic [1:0] {
      CSR_SCREEN_HEIGHT,
      CSR_SCREEN_WIDTH,
      CSR_SKY_COLOR,
      CSR_GROUND_COLOR
   } csr_index_type;

   typedef struct packed {
      logic [10:0] screen_height;
      logic [11:0] screen_width;
      logic [23:0] sky_color;
      logic [23:0] ground_color;
   } cfg_type;

   typedef struct packed {
      kind_type               kind;
      face_type               face;
      logic [TY_BITS-1:0]     tcol;
      logic [ADDR_BITS-1:0]   load_addr;
      logic [23:0]            texel_color;
      logic [20:0]            row_base;
      logic [10:0]            column;
   } item_type;

   typedef struct packed {
      logic [NUM_BITS-1:0]    num;
      logic [15:0]            line_height;
      item_type               item;
   } div_req_type;

   typedef struct packed {
      logic [TY_BITS-1:0]     quot;
      item_type               item;
   } div_rsp_type;

endpackage

/* rtl/core/raycast_wall_column_shader.sv */
// Top level of the raycaster wall column shader: configuration registers and pipeline.
// Throughput: one request per cycle while the result port is not stalled; the texel store
// is read or written at most once per request.
// Reset clears all pipeline valids and loads the default registers; the texel store
// is not cleared and holds undefined data until loaded.
module raycast_wall_column_shader (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [23:0]          csr_write_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_cmd,
   input  logic [1:0]           req_texture_face,
   input  logic [11:0]          req_texel_index,
   input  logic [23:0]          req_texel_color,
   input  logic [9:0]           req_row,
   input  logic [10:0]          req_column,
   input  logic [15:0]          req_line_height,
   input  logic                 req_hit_side,
   input  logic signed [1:0]    req_ray_x_sign,
   input  logic signed [1:0]    req_ray_y_sign,
   input  logic [5:0]           req_tex_column,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [20:0]          rsp_pixel_index,
   output logic [23:0]          rsp_pixel_color
);

   rcws_pkg::cfg_type       cfg_ff;
   rcws_pkg::cfg_type       cfg_in;

   logic                    front_valid;
   logic                    front_ready;
   rcws_pkg::div_req_type   div_req;
   logic                    div_valid;
   logic                    div_ready;
   rcws_pkg::div_rsp_type   div_rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (rcws_pkg::csr_index_type'(csr_index))
            rcws_pkg::CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_write_data[10:0];
            rcws_pkg::CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_write_data[11:0];
            rcws_pkg::CSR_SKY_COLOR:     cfg_in.sky_color     = csr_write_data;
            rcws_pkg::CSR_GROUND_COLOR:  cfg_in.ground_color  = csr_write_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_height <= 11'd480;
         cfg_ff.screen_width  <= 12'd640;
         cfg_ff.sky_color     <= 24'd0;
         cfg_ff.ground_color  <= 24'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rcws_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_texture_face (req_texture_face),
      .req_texel_index  (req_texel_index),
      .req_texel_color  (req_texel_color),
      .req_row          (req_row),
      .req_column       (req_column),
      .req_line_height  (req_line_height),
      .req_hit_side     (req_hit_side),
      .req_ray_x_sign   (req_ray_x_sign),
      .req_ray_y_sign   (req_ray_y_sign),
      .req_tex_column   (req_tex_column),
      .out_valid        (front_valid),
      .out_ready        (front_ready),
      .div_req          (div_req)
   );

   rcws_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .div_req   (div_req),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .div_rsp   (div_rsp)
   );

   rcws_shade u_shade (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .in_valid        (div_valid),
      .in_ready        (div_ready),
      .div_rsp         (div_rsp),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_pixel_color (rsp_pixel_color)
   );

   a_ready_after_reset: assert property (@(posedge clock) $past(reset) |-> req_ready)
      else $error("Request port is not ready right after reset.");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("Request port stalled while the result port is not stalled.");

   a_cfg_holds: assert property (@(posedge clock) disable iff (reset)
      !csr_write_enable |=> $stable(cfg_ff))
      else $error("Configuration changed without a register write.");

endmodule

/* rtl/core/rcws_front.sv */
// Request register, wall span clamping and pixel classification stages.
module rcws_front (
   input  logic                    clock,
   input  logic                    reset,
   input  rcws_pkg::cfg_type       cfg,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_cmd,
   input  logic [1:0]              req_texture_face,
   input  logic [11:0]             req_texel_index,
   input  logic [23:0]             req_texel_color,
   input  logic [9:0]              req_row,
   input  logic [10:0]             req_column,
   input  logic [15:0]             req_line_height,
   input  logic                    req_hit_side,
   input  logic signed [1:0]       req_ray_x_sign,
   input  logic signed [1:0]       req_ray_y_sign,
   input  logic [5:0]              req_tex_column,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rcws_pkg::div_req_type   div_req
);

   typedef struct packed {
      logic        cmd;
      logic [1:0]  texture_face;
      logic [11:0] texel_index;
      logic [23:0] texel_color;
      logic [9:0]  row;
      logic [10:0] column;
      logic [15:0] line_height;
      logic        hit_side;
      logic [1:0]  ray_x_sign;
      logic [1:0]  ray_y_sign;
      logic [5:0]  tex_column;
   } raw_type;

   typedef struct packed {
      logic                             is_shade;
      logic                             load_ok;
      logic                             off_screen;
      logic                             wall_nz;
      logic                             face_ok;
      logic [9:0]                       row;
      logic [9:0]                       wall_start;
      logic [10:0]                      wall_end;
      logic [rcws_pkg::SPAN_BITS-1:0]   span;
      logic [15:0]                      line_height;
      rcws_pkg::item_type               item;
   } span_type;

   logic                   a_vld_ff;
   raw_type                a_req_ff;
   raw_type                a_req_in;
   logic                   b_vld_ff;
   span_type               b_stage_ff;
   span_type               b_stage_in;
   logic                   c_vld_ff;
   rcws_pkg::div_req_type  c_stage_ff;
   rcws_pkg::div_req_type  c_stage_in;

   logic                   a_rdy;
   logic                   b_rdy;
   logic                   c_rdy;

   logic [10:0]            h;
   logic [11:0]            w;
   logic [9:0]             half_h;
   logic [14:0]            half_lh;
   logic [15:0]            start_diff;
   logic [15:0]            end_sum;
   logic [21:0]            prod;
   logic                   face_ok;
   rcws_pkg::face_type     face_sel;

   assign c_rdy     = !c_vld_ff || out_ready;
   assign b_rdy     = !b_vld_ff || c_rdy;
   assign a_rdy     = !a_vld_ff || b_rdy;
   assign req_ready = a_rdy;
   assign out_valid = c_vld_ff;
   assign div_req   = c_stage_ff;

   always_comb begin
      a_req_in.cmd          = req_cmd;
      a_req_in.texture_face = req_texture_face;
      a_req_in.texel_index  = req_texel_index;
      a_req_in.texel_color  = req_texel_color;
      a_req_in.row          = req_row;
      a_req_in.column       = req_column;
      a_req_in.line_height  = req_line_height;
      a_req_in.hit_side     = req_hit_side;
      a_req_in.ray_x_sign   = req_ray_x_sign;
      a_req_in.ray_y_sign   = req_ray_y_sign;
      a_req_in.tex_column   = req_tex_column;
   end

   always_comb begin
      face_ok  = 1'b1;
      face_sel = rcws_pkg::FACE_NORTH;
      if (!a_req_ff.hit_side) begin
         if (a_req_ff.ray_x_sign[1]) begin
            face_sel = rcws_pkg::FACE_NORTH;
         end else if (a_req_ff.ray_x_sign == 2'b01) begin
            face_sel = rcws_pkg::FACE_SOUTH;
         end else begin
            face_ok = 1'b0;
         end
      end else begin
         if (a_req_ff.ray_y_sign == 2'b01) begin
            face_sel = rcws_pkg::FACE_EAST;
         end else if (a_req_ff.ray_y_sign[1]) begin
            face_sel = rcws_pkg::FACE_WEST;
         end else begin
            face_ok = 1'b0;
         end
      end
   end

   always_comb begin
      h = (32'(cfg.screen_height) > rcws_pkg::MAX_HEIGHT) ?
          11'(rcws_pkg::MAX_HEIGHT) : cfg.screen_height;
      w = (32'(cfg.screen_width) > rcws_pkg::MAX_WIDTH) ?
          12'(rcws_pkg::MAX_WIDTH) : cfg.screen_width;
      half_h     = h[10:1];
      half_lh    = a_req_ff.line_height[15:1];
      start_diff = {6'd0, half_h} - {1'b0, half_lh};
      end_sum    = {6'd0, half_h} + {1'b0, half_lh};
      prod       = {12'd0, a_req_ff.row} * {10'd0, w};

      b_stage_in.is_shade    = (a_req_ff.cmd != rcws_pkg::CMD_LOAD);
      b_stage_in.load_ok     = (32'(a_req_ff.texel_index) < rcws_pkg::FACE_TEXELS);
      b_stage_in.off_screen  = ({1'b0, a_req_ff.row} >= h) || ({1'b0, a_req_ff.column} >= w);
      b_stage_in.wall_nz     = (a_req_ff.line_height != 16'd0);
      b_stage_in.face_ok     = face_ok;
      b_stage_in.row         = a_req_ff.row;
      b_stage_in.wall_start  = ({1'b0, half_lh} > {6'd0, half_h}) ? 10'd0 : start_diff[9:0];
      b_stage_in.wall_end    = (end_sum >= {5'd0, h}) ? h - 11'd1 : end_sum[10:0];
      b_stage_in.span        = {7'd0, a_req_ff.row, 1'b0} - {7'd0, h}
                             + {2'd0, a_req_ff.line_height};
      b_stage_in.line_height = a_req_ff.line_height;

      b_stage_in.item.kind        = rcws_pkg::KIND_DROP;
      b_stage_in.item.face        = face_sel;
      b_stage_in.item.tcol        = (32'(a_req_ff.tex_column) > rcws_pkg::TEX_SIZE - 1) ?
                                    rcws_pkg::TY_BITS'(rcws_pkg::TEX_SIZE - 1) :
                                    rcws_pkg::TY_BITS'(a_req_ff.tex_column);
      b_stage_in.item.load_addr   = rcws_pkg::ADDR_BITS'(
                                    32'(a_req_ff.texture_face) * rcws_pkg::FACE_TEXELS
                                    + 32'(a_req_ff.texel_index));
      b_stage_in.item.texel_color = a_req_ff.texel_color;
      b_stage_in.item.row_base    = prod[20:0];
      b_stage_in.item.column      = a_req_ff.column;
   end

   always_comb begin
      c_stage_in.line_height = b_stage_ff.line_height;
      c_stage_in.item        = b_stage_ff.item;
      c_stage_in.num         = b_stage_ff.span[rcws_pkg::SPAN_BITS-1] ? '0 :
                               rcws_pkg::NUM_BITS'(32'(b_stage_ff.span[rcws_pkg::SPAN_BITS-2:0])
                                                   * rcws_pkg::HALF_TEX);
      if (!b_stage_ff.is_shade) begin
         c_stage_in.item.kind = b_stage_ff.load_ok ? rcws_pkg::KIND_LOAD : rcws_pkg::KIND_DROP;
      end else if (b_stage_ff.off_screen) begin
         c_stage_in.item.kind = rcws_pkg::KIND_DROP;
      end else if (b_stage_ff.row < b_stage_ff.wall_start) begin
         c_stage_in.item.kind = rcws_pkg::KIND_SKY;
      end else if (({1'b0, b_stage_ff.row} < b_stage_ff.wall_end) && b_stage_ff.wall_nz) begin
         c_stage_in.item.kind = b_stage_ff.face_ok ? rcws_pkg::KIND_WALL : rcws_pkg::KIND_DROP;
      end else begin
         c_stage_in.item.kind = rcws_pkg::KIND_GROUND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         if (a_rdy) begin
            a_vld_ff <= req_valid;
         end
         if (b_rdy) begin
            b_vld_ff <= a_vld_ff;
         end
         if (c_rdy) begin
            c_vld_ff <= b_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_rdy && req_valid) begin
         a_req_ff <= a_req_in;
      end
      if (b_rdy && a_vld_ff) begin
         b_stage_ff <= b_stage_in;
      end
      if (c_rdy && b_vld_ff) begin
         c_stage_ff <= c_stage_in;
      end
   end

endmodule

/* rtl/core/rcws_divider.sv */
// Pipelined restoring divider for the saturated texture row, a row bit per later stage.
module rcws_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  rcws_pkg::div_req_type   div_req,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rcws_pkg::div_rsp_type   div_rsp
);

   localparam int LAST = rcws_pkg::DIV_STAGES - 1;

   logic                            vld_ff    [rcws_pkg::DIV_STAGES];
   logic [rcws_pkg::NUM_BITS-1:0]   rem_ff    [rcws_pkg::DIV_STAGES];
   logic [15:0]                     lh_ff     [rcws_pkg::DIV_STAGES];
   logic [rcws_pkg::TY_BITS-1:0]    quot_ff   [rcws_pkg::DIV_STAGES];
   rcws_pkg::item_type              item_ff   [rcws_pkg::DIV_STAGES];
   logic                            stage_rdy [rcws_pkg::DIV_STAGES+1];

   assign stage_rdy[rcws_pkg::DIV_STAGES] = out_ready;
   assign in_ready     = stage_rdy[0];
   assign out_valid    = vld_ff[LAST];
   assign div_rsp.quot = quot_ff[LAST];
   assign div_rsp.item = item_ff[LAST];

   for (genvar i = 0; i < rcws_pkg::DIV_STAGES; i++) begin : g_stage
      // The first stage only detects a quotient too large for the row bits.
      localparam int SHIFT = (i == 0) ? rcws_pkg::TY_BITS : rcws_pkg::TY_BITS - i;

      logic                            src_vld;
      logic [rcws_pkg::NUM_BITS-1:0]   src_rem;
      logic [15:0]                     src_lh;
      logic [rcws_pkg::TY_BITS-1:0]    src_quot;
      rcws_pkg::item_type              src_item;
      logic [rcws_pkg::NUM_BITS-1:0]   dvs;
      logic [rcws_pkg::NUM_BITS-1:0]   rem_in;
      logic [rcws_pkg::TY_BITS-1:0]    quot_in;
      logic                            take_bit;

      if (i == 0) begin : g_first
         assign src_vld  = in_valid;
         assign src_rem  = div_req.num;
         assign src_lh   = div_req.line_height;
         assign src_quot = '0;
         assign src_item = div_req.item;
      end else begin : g_next
         assign src_vld  = vld_ff[i-1];
         assign src_rem  = rem_ff[i-1];
         assign src_lh   = lh_ff[i-1];
         assign src_quot = quot_ff[i-1];
         assign src_item = item_ff[i-1];
      end

      always_comb begin
         dvs      = rcws_pkg::NUM_BITS'(src_lh) << SHIFT;
         take_bit = (src_rem >= dvs);
         if (i == 0) begin
            rem_in  = src_rem;
            quot_in = take_bit ? '1 : '0;
         end else begin
            rem_in  = take_bit ? src_rem - dvs : src_rem;
            quot_in = src_quot | (rcws_pkg::TY_BITS'(take_bit) << SHIFT);
         end
      end

      assign stage_rdy[i] = !vld_ff[i] || stage_rdy[i+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (stage_rdy[i]) begin
            vld_ff[i] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_rdy[i] && src_vld) begin
            rem_ff[i]  <= rem_in;
            lh_ff[i]   <= src_lh;
            quot_ff[i] <= quot_in;
            item_ff[i] <= src_item;
         end
      end
   end

endmodule

/* rtl/core/rcws_shade.sv */
// Texel store access and result register of the wall column shader.
module rcws_shade (
   input  logic                    clock,
   input  logic                    reset,
   input  rcws_pkg::cfg_type       cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  rcws_pkg::div_rsp_type   div_rsp,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [20:0]             rsp_pixel_index,
   output logic [23:0]             rsp_pixel_color
);

   logic [23:0]                     texel_mem [rcws_pkg::STORE_DEPTH];
   logic [23:0]                     texel_rd_ff;
   logic                            o_vld_ff;
   logic                            o_wall_ff;
   logic [23:0]                     o_color_ff;
   logic [20:0]                     o_index_ff;

   logic                            take;
   logic                            is_result;
   logic [rcws_pkg::TY_BITS-1:0]    ty;
   logic [rcws_pkg::ADDR_BITS-1:0]  rd_addr;

   assign in_ready        = !o_vld_ff || rsp_ready;
   assign take            = in_valid && in_ready;
   assign rsp_valid       = o_vld_ff;
   assign rsp_pixel_index = o_index_ff;
   assign rsp_pixel_color = o_wall_ff ? texel_rd_ff : o_color_ff;

   always_comb begin
      is_result = div_rsp.item.kind inside {rcws_pkg::KIND_SKY, rcws_pkg::KIND_WALL,
                                            rcws_pkg::KIND_GROUND};
      ty        = (32'(div_rsp.quot) > rcws_pkg::TEX_SIZE - 1) ?
                  rcws_pkg::TY_BITS'(rcws_pkg::TEX_SIZE - 1) : div_rsp.quot;
      rd_addr   = rcws_pkg::ADDR_BITS'(32'(div_rsp.item.face) * rcws_pkg::FACE_TEXELS
                                       + 32'(ty) * rcws_pkg::TEX_SIZE
                                       + 32'(div_rsp.item.tcol));
   end

   always_ff @(posedge clock) begin
      if (take && (div_rsp.item.kind == rcws_pkg::KIND_LOAD)) begin
         texel_mem[div_rsp.item.load_addr] <= div_rsp.item.texel_color;
      end
      if (take && (div_rsp.item.kind == rcws_pkg::KIND_WALL)) begin
         texel_rd_ff <= texel_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (in_ready) begin
         o_vld_ff <= in_valid && is_result;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         o_wall_ff  <= (div_rsp.item.kind == rcws_pkg::KIND_WALL);
         o_color_ff <= (div_rsp.item.kind == rcws_pkg::KIND_SKY) ? cfg.sky_color :
                                                                    cfg.ground_color;
         o_index_ff <= div_rsp.item.row_base + 21'(div_rsp.item.column);
      end
   end

endmodule
